// ----- hw/rtl/rc4_pkg.sv -----
// Shared types, constants and register indexes of the RC4 stream cipher.
package rc4_pkg;

	localparam int TABLE_SIZE    = 256;
	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = CFG_INDEX_W'(2);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KRA,
		ST_KRB,
		ST_KWA,
		ST_KWB,
		ST_RDI,
		ST_RDJ,
		ST_WRI,
		ST_WRJ,
		ST_RDT,
		ST_OUT
	} state_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT_WR,
		OP_SCHED_RDA,
		OP_SCHED_RDB,
		OP_SCHED_WRA,
		OP_SCHED_WRB,
		OP_RD_I,
		OP_RD_J,
		OP_WR_I,
		OP_WR_J,
		OP_RD_T,
		OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic latch_in;
	} cmd_t;

	typedef struct packed {
		logic a_last;
	} status_t;

endpackage

// ----- hw/rtl/rc4_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_message;

	modport source (output valid, output data_byte, output start_message, input ready);
	modport sink (input valid, input data_byte, input start_message, output ready);
endinterface

interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink (input valid, input result_byte, output ready);
endinterface

// ----- hw/rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher top level: XORs each input byte with the next keystream byte.
// The key (1 to 16 bytes, key_length register) is taken from key_low and key_high.
// A transaction flagged start_message, and the first one after reset, first runs
// the key schedule: it loads the identity permutation, then makes 256 keyed swaps
// of two reads and two writes each. Each byte then reads S[i], reads S[j], writes
// both back swapped, reads the keystream byte and loads the result, waiting while
// the output register is full; the next byte is accepted only after that. The
// single read and write ports of the 256 x 8 permutation memory fix this order.
// A finished result sits in an output register, so the next transaction is taken
// while it waits. Write configuration only while the block is idle.
module rc4_stream_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	rc4_in_if.sink                          data_in,
	rc4_out_if.source                       data_out,
	input  logic                            cfg_write,
	input  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rc4_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (data_in.valid),
		.in_ready  (data_in.ready),
		.in_start  (data_in.start_message),
		.out_valid (data_out.valid),
		.out_ready (data_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Memory and arithmetic.
	rc4_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_in.data_byte),
		.result_byte (data_out.result_byte),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// ----- hw/rtl/rc4_ctrl.sv -----
// Sequencer that steps the key schedule and the per-byte keystream work.
module rc4_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_start,
	output logic            out_valid,
	input  logic            out_ready,
	output rc4_pkg::cmd_t   cmd,
	input  rc4_pkg::status_t status
);
	import rc4_pkg::*;

	state_t state_q, state_d;
	logic   keyed_q, keyed_d;
	logic   out_valid_q, out_valid_d;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// State, keyed flag and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			keyed_q     <= keyed_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		keyed_d      = keyed_q;
		out_valid_d  = out_valid_q;
		cmd.op       = OP_NONE;
		cmd.latch_in = 1'b0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch_in = 1'b1;
					state_d      = (in_start || !keyed_q) ? ST_INIT : ST_RDI;
				end
			end
			ST_INIT: begin
				cmd.op = OP_INIT_WR;
				if (status.a_last) begin
					state_d = ST_KRA;
				end
			end
			ST_KRA: begin
				cmd.op  = OP_SCHED_RDA;
				state_d = ST_KRB;
			end
			ST_KRB: begin
				cmd.op  = OP_SCHED_RDB;
				state_d = ST_KWA;
			end
			ST_KWA: begin
				cmd.op  = OP_SCHED_WRA;
				state_d = ST_KWB;
			end
			ST_KWB: begin
				cmd.op = OP_SCHED_WRB;
				if (status.a_last) begin
					keyed_d = 1'b1;
					state_d = ST_RDI;
				end else begin
					state_d = ST_KRA;
				end
			end
			ST_RDI: begin
				cmd.op  = OP_RD_I;
				state_d = ST_RDJ;
			end
			ST_RDJ: begin
				cmd.op  = OP_RD_J;
				state_d = ST_WRI;
			end
			ST_WRI: begin
				cmd.op  = OP_WR_I;
				state_d = ST_WRJ;
			end
			ST_WRJ: begin
				cmd.op  = OP_WR_J;
				state_d = ST_RDT;
			end
			ST_RDT: begin
				cmd.op  = OP_RD_T;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// Wait until the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_LOAD_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/rc4_datapath.sv -----
// Permutation memory, indices, key registers and result register.
module rc4_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rc4_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                         data_byte,
	output logic [7:0]                         result_byte,
	input  rc4_pkg::cmd_t                      cmd,
	output rc4_pkg::status_t                   status
);
	import rc4_pkg::*;

	logic [7:0]            perm_mem [TABLE_SIZE];
	logic [7:0]            rdata_q;
	logic                  we, re;
	logic [7:0]            waddr, wdata, raddr;

	logic [KEY_LEN_W-1:0]  key_len_q;
	logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
	logic [7:0]            a_q, b_q, i_q, j_q, va_q, data_q, result_q;
	logic [3:0]            k_q;
	logic [KEY_LEN_W-1:0]  eff_len;
	logic                  k_last;
	logic [7:0]            key_byte;
	logic [7:0]            b_next, i_next, j_next;
	logic [2*CFG_DATA_W-1:0] key_all;

	assign status.a_last = (a_q == 8'hFF);
	assign result_byte   = result_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q  <= KEY_LEN_RESET;
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_KEY_LENGTH) begin
				key_len_q <= cfg_data[KEY_LEN_W-1:0];
			end else if (cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end else if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
		end
	end

	// Effective key length: zero counts as one, longer keys saturate.
	always_comb begin
		if (key_len_q == '0) begin
			eff_len = KEY_LEN_W'(1);
		end else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			eff_len = key_len_q;
		end
	end

	assign k_last   = ({1'b0, k_q} == KEY_LEN_W'(eff_len - KEY_LEN_W'(1)));
	assign key_all  = {key_high_q, key_low_q};
	assign key_byte = key_all[{k_q, 3'b000} +: 8];
	assign b_next   = 8'(b_q + rdata_q + key_byte);
	assign i_next   = 8'(i_q + 8'd1);
	assign j_next   = 8'(j_q + rdata_q);

	// Memory port control for each operation.
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = a_q;
		wdata = rdata_q;
		raddr = a_q;
		unique case (cmd.op)
			OP_INIT_WR: begin
				we    = 1'b1;
				wdata = a_q;
			end
			OP_SCHED_RDA: begin
				re = 1'b1;
			end
			OP_SCHED_RDB: begin
				re    = 1'b1;
				raddr = b_next;
			end
			OP_SCHED_WRA: begin
				we = 1'b1;
			end
			OP_SCHED_WRB: begin
				we    = 1'b1;
				waddr = b_q;
				wdata = va_q;
			end
			OP_RD_I: begin
				re    = 1'b1;
				raddr = i_next;
			end
			OP_RD_J: begin
				re    = 1'b1;
				raddr = j_next;
			end
			OP_WR_I: begin
				we    = 1'b1;
				waddr = i_q;
			end
			OP_WR_J: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = va_q;
			end
			OP_RD_T: begin
				re    = 1'b1;
				raddr = 8'(va_q + rdata_q);
			end
			OP_NONE, OP_LOAD_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Permutation memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			perm_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= perm_mem[raddr];
		end
	end

	// Schedule counters and cipher indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.latch_in) begin
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_INIT_WR: begin
					a_q <= 8'(a_q + 8'd1);
				end
				OP_SCHED_RDB: begin
					b_q <= b_next;
					k_q <= k_last ? 4'd0 : 4'(k_q + 4'd1);
				end
				OP_SCHED_WRB: begin
					a_q <= 8'(a_q + 8'd1);
					if (status.a_last) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				OP_RD_I: begin
					i_q <= i_next;
				end
				OP_RD_J: begin
					j_q <= j_next;
				end
				default: begin
				end
			endcase
		end
	end

	// Held operands, input byte and result register.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			data_q <= data_byte;
		end
		if (cmd.op == OP_SCHED_RDB || cmd.op == OP_RD_J) begin
			va_q <= rdata_q;
		end
		if (cmd.op == OP_LOAD_OUT) begin
			result_q <= data_q ^ rdata_q;
		end
	end

endmodule
